// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and helpers for the trickle timer
// Holds the time width, the item and result structures, the configuration
// register indexes and the interval and fire point arithmetic.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Width of the elapsed time counter and the fire point.
  localparam int TIME_W = 32;

  // Largest interval exponent that still fits the time counter.
  localparam logic [5:0] EXP_MAX = 6'(TIME_W - 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_SUPPRESS  = 2'd0;
  localparam logic [1:0] REG_MIN_LOG2  = 2'd1;
  localparam logic [1:0] REG_MAX_DBL   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SUPPRESS_RST = 8'd1;
  localparam logic [4:0] MIN_LOG2_RST = 5'd9;
  localparam logic [3:0] MAX_DBL_RST  = 4'd4;

  // Item kinds carried in the input tuser bit.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MSG  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] recv_id;
    logic [15:0] rand_value;
    logic        dup_coin;
  } tts_item_t;

  typedef struct packed {
    logic [7:0] suppress_threshold;
    logic [4:0] min_interval_log2;
    logic [3:0] max_doublings;
  } tts_cfg_t;

  typedef struct packed {
    logic        send;
    logic [31:0] sent_id;
    logic        is_duplicate;
  } tts_result_t;

  // Interval length 2^(min_log2 + dc), exponent saturated to the counter width.
  function automatic logic [TIME_W-1:0] interval_len(input logic [4:0] min_log2,
                                                     input logic [3:0] dc);
    logic [5:0] e;
    e = {1'b0, min_log2} + {2'b00, dc};
    if (e > EXP_MAX) begin
      e = EXP_MAX;
    end
    return {{(TIME_W-1){1'b0}}, 1'b1} << e;
  endfunction

  // Fire point I/2 + (rnd & (I/2 - 1)); zero when the half interval is zero.
  function automatic logic [TIME_W-1:0] draw_fire(input logic [TIME_W-1:0] ilen,
                                                  input logic [15:0] rnd);
    logic [TIME_W-1:0] half;
    half = ilen >> 1;
    if (half == '0) begin
      return '0;
    end
    return half + (TIME_W'(rnd) & (half - {{(TIME_W-1){1'b0}}, 1'b1}));
  endfunction

endpackage

// File: rtl/tts_core.sv
// ----------------------------------------------------------------------------
// tts_core: trickle timer state and combinational next-state update
// Holds the interval state and works out, for the item in the input register,
// the result and the next state in one pass of short logic.
// ----------------------------------------------------------------------------
module tts_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  tts_pkg::tts_item_t   item,
  input  tts_pkg::tts_cfg_t    cfg,
  output tts_pkg::tts_result_t result
);

  logic [3:0]                 dbl_r, dbl_nxt;
  logic [tts_pkg::TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [tts_pkg::TIME_W-1:0] fire_r, fire_nxt;
  logic [7:0]                 heard_r, heard_nxt;
  logic                       fired_r, fired_nxt;
  logic [31:0]                last_id_r, last_id_nxt;
  logic [31:0]                seq_r, seq_nxt;

  logic [tts_pkg::TIME_W-1:0] el_inc;
  logic [3:0]                 dbl_up;
  logic                       fire_now;
  logic                       dup_ok;

  // Next state and result for the current item.
  always_comb begin
    dbl_nxt     = dbl_r;
    elapsed_nxt = elapsed_r;
    fire_nxt    = fire_r;
    heard_nxt   = heard_r;
    fired_nxt   = fired_r;
    last_id_nxt = last_id_r;
    seq_nxt     = seq_r;
    result      = '0;

    el_inc   = elapsed_r + {{(tts_pkg::TIME_W-1){1'b0}}, 1'b1};
    dbl_up   = (dbl_r < cfg.max_doublings) ? dbl_r + 4'd1 : cfg.max_doublings;
    fire_now = !fired_r && (el_inc >= fire_r);
    dup_ok   = !item.dup_coin && (seq_r > 32'd1);

    if (item.action == tts_pkg::ACT_MSG) begin
      // A matching id is consistent; a new one restarts a longer interval at the minimum.
      if (item.recv_id == last_id_r) begin
        if (heard_r != 8'hFF) begin
          heard_nxt = heard_r + 8'd1;
        end
      end else begin
        last_id_nxt = item.recv_id;
        if (dbl_r != 4'd0) begin
          dbl_nxt     = 4'd0;
          elapsed_nxt = '0;
          fired_nxt   = 1'b0;
          fire_nxt    = tts_pkg::draw_fire(
                          tts_pkg::interval_len(cfg.min_interval_log2, 4'd0),
                          item.rand_value);
          heard_nxt   = 8'd0;
        end
      end
    end else begin
      elapsed_nxt = el_inc;

      // Transmit decision, once per interval.
      if (fire_now) begin
        fired_nxt = 1'b1;
        if (heard_r < cfg.suppress_threshold) begin
          result.send = 1'b1;
          if (dup_ok) begin
            result.sent_id      = seq_r - 32'd1;
            result.is_duplicate = 1'b1;
          end else begin
            result.sent_id = seq_r;
            seq_nxt        = seq_r + 32'd1;
          end
        end
      end

      // End of interval: double, draw a new fire point, clear the count.
      if (el_inc >= tts_pkg::interval_len(cfg.min_interval_log2, dbl_r)) begin
        dbl_nxt     = dbl_up;
        elapsed_nxt = '0;
        fired_nxt   = 1'b0;
        fire_nxt    = tts_pkg::draw_fire(
                        tts_pkg::interval_len(cfg.min_interval_log2, dbl_up),
                        item.rand_value);
        heard_nxt   = 8'd0;
      end
    end
  end

  // State registers, updated only when an item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r     <= 4'd0;
      elapsed_r <= '0;
      fire_r    <= tts_pkg::interval_len(tts_pkg::MIN_LOG2_RST, 4'd0) >> 1;
      heard_r   <= 8'd0;
      fired_r   <= 1'b0;
      last_id_r <= 32'd0;
      seq_r     <= 32'd1;
    end else if (step) begin
      dbl_r     <= dbl_nxt;
      elapsed_r <= elapsed_nxt;
      fire_r    <= fire_nxt;
      heard_r   <= heard_nxt;
      fired_r   <= fired_nxt;
      last_id_r <= last_id_nxt;
      seq_r     <= seq_nxt;
    end
  end

endmodule

// File: rtl/trickle_timer_suppression.sv
// ----------------------------------------------------------------------------
// trickle_timer_suppression: trickle timer with transmit suppression
// Streams tick and message items through an input register and the timer
// update into an output register; holds the configuration registers.
// ----------------------------------------------------------------------------
// Each input item is one timer tick (tuser 0) or one received message id
// (tuser 1). A tick that reaches the fire point of the current interval sends
// one result item, unless enough consistent ids were heard; messages never
// produce results. Each item passes through the state update between the
// input register and the output register, so one item is accepted every clock
// while the result side keeps up; a stalled output holds the pipeline after
// one more item has been taken into the input register. Configuration writes
// are always accepted and should be made only while no item is in flight.
module trickle_timer_suppression (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // recv_id[31:0], rand_value[47:32], dup_coin[48], zero
  input  logic        in_tuser,   // action
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // sent_id[31:0]
  output logic        out_tuser,  // is_duplicate
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tts_pkg::tts_item_t   item_r;
  logic                 in_valid_r;
  tts_pkg::tts_cfg_t    cfg_r;
  tts_pkg::tts_result_t result;
  logic                 out_valid_r;
  logic [31:0]          out_id_r;
  logic                 out_dup_r;
  logic                 consume;
  logic                 step;

  // The stage moves on whenever the output register is free or emptying.
  assign consume   = !out_valid_r || out_tready;
  assign step      = in_valid_r && consume;
  assign in_tready = !in_valid_r || consume;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action     <= in_tuser;
      item_r.recv_id    <= in_tdata[31:0];
      item_r.rand_value <= in_tdata[47:32];
      item_r.dup_coin   <= in_tdata[48];
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.suppress_threshold <= tts_pkg::SUPPRESS_RST;
      cfg_r.min_interval_log2  <= tts_pkg::MIN_LOG2_RST;
      cfg_r.max_doublings      <= tts_pkg::MAX_DBL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tts_pkg::REG_SUPPRESS: cfg_r.suppress_threshold <= cfg_data;
        tts_pkg::REG_MIN_LOG2: cfg_r.min_interval_log2  <= cfg_data[4:0];
        tts_pkg::REG_MAX_DBL:  cfg_r.max_doublings      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && result.send) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.send) begin
      out_id_r  <= result.sent_id;
      out_dup_r <= result.is_duplicate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_dup_r;

endmodule

// File: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the trickle timer
// Watches the top level's ports and flags results or handshakes that the
// design must never show.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the output register empty, the input side is never stalled.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A duplicate repeats an earlier new id, which is never zero.
  a_dup_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata != 32'd0)
    else $error("duplicate of id zero");

endmodule

bind trickle_timer_suppression tts_checker u_tts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: test/trickle_timer_suppression_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trickle_timer_suppression_test: self-checking bench for the trickle timer
// Drives tick and message items against a local timer predictor and compares
// every sent id in order. A directed table covers the corner cases, then a
// series of register settings runs random traffic with random stalls.
// ----------------------------------------------------------------------------
module trickle_timer_suppression_test;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 22;

  typedef enum logic [1:0] {CHK_MODEL, CHK_SEND, CHK_NONE} pin_t;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [31:0] sent_id;
    logic        is_duplicate;
  } send_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [7:0]         val;
    tts_pkg::tts_item_t item;
    pin_t               pin;
    send_t              want;
  } plan_row_t;

  typedef struct packed {
    int thresh;
    int min_log2;
    int max_dbl;
    int n_items;
    int msg_pct;
    bit burst;
    bit calm;
    bit squeeze;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // recv_id[31:0], rand_value[47:32], dup_coin[48], zero
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // sent_id[31:0]
  logic        out_tuser;  // is_duplicate
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Expectation override carried along with each offered item.
  pin_t  pin_kind;
  send_t pin_want;

  // Predicted sends waiting for the block to deliver them.
  send_t sends_due[$];

  int err_count    = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int stall_cycles = 0;
  bit calm         = 1'b0;
  bit squeeze_req  = 1'b0;

  // Predictor copy of the registers and the timer state.
  logic [7:0]                 thr_k;
  logic [4:0]                 min_log2_r;
  logic [3:0]                 max_dbl_r;
  logic [3:0]                 dbl_cnt;
  logic [tts_pkg::TIME_W-1:0] elapsed;
  logic [tts_pkg::TIME_W-1:0] fire_at;
  logic [7:0]                 heard;
  bit                         fired;
  logic [31:0]                last_id;
  logic [31:0]                next_seq;

  trickle_timer_suppression u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Interval length for a doubling count; the exponent stops at the counter top bit.
  function automatic logic [tts_pkg::TIME_W-1:0] span_of(input logic [3:0] dc);
    int unsigned e;
    e = 32'(min_log2_r) + 32'(dc);
    if (e > tts_pkg::TIME_W - 1) begin
      e = tts_pkg::TIME_W - 1;
    end
    return {{(tts_pkg::TIME_W-1){1'b0}}, 1'b1} << e;
  endfunction

  // Fire point in the second half of an interval, or zero when the half is zero.
  function automatic logic [tts_pkg::TIME_W-1:0] fire_from(
      input logic [tts_pkg::TIME_W-1:0] len, input logic [15:0] rnd);
    logic [tts_pkg::TIME_W-1:0] half;
    logic [tts_pkg::TIME_W-1:0] r;
    half = len >> 1;
    r = '0;
    r[15:0] = rnd;
    if (half == '0) begin
      return '0;
    end
    return half + (r & (half - {{(tts_pkg::TIME_W-1){1'b0}}, 1'b1}));
  endfunction

  // Advances the timer by one item; returns 1 when the item sends.
  function automatic bit timer_advance(input tts_pkg::tts_item_t it, output send_t s);
    bit sends;
    sends = 1'b0;
    s = '0;
    if (it.action == tts_pkg::ACT_MSG) begin
      if (it.recv_id == last_id) begin
        if (heard != 8'hFF) begin
          heard = heard + 8'd1;
        end
      end else begin
        last_id = it.recv_id;
        // A new id restarts a minimum interval unless already there.
        if (dbl_cnt != 4'd0) begin
          dbl_cnt = 4'd0;
          elapsed = '0;
          fired   = 1'b0;
          fire_at = fire_from(span_of(4'd0), it.rand_value);
          heard   = 8'd0;
        end
      end
      return 1'b0;
    end
    elapsed = elapsed + {{(tts_pkg::TIME_W-1){1'b0}}, 1'b1};
    // One send decision per interval, when the fire point is first reached.
    if (!fired && elapsed >= fire_at) begin
      fired = 1'b1;
      if (heard < thr_k) begin
        sends = 1'b1;
        if (it.dup_coin == 1'b0 && next_seq > 32'd1) begin
          s.sent_id      = next_seq - 32'd1;
          s.is_duplicate = 1'b1;
        end else begin
          s.sent_id      = next_seq;
          s.is_duplicate = 1'b0;
          next_seq       = next_seq + 32'd1;
        end
      end
    end
    // Interval end: double up to the cap and draw the next fire point.
    if (elapsed >= span_of(dbl_cnt)) begin
      dbl_cnt = (dbl_cnt < max_dbl_r) ? dbl_cnt + 4'd1 : max_dbl_r;
      elapsed = '0;
      fired   = 1'b0;
      fire_at = fire_from(span_of(dbl_cnt), it.rand_value);
      heard   = 8'd0;
    end
    return sends;
  endfunction

  // Checks delivered sends, tracks register writes and predicts accepted items.
  always @(posedge clk) begin : scoreboard
    send_t              got;
    send_t              due;
    tts_pkg::tts_item_t it;
    bit                 sends;
    if (!rst_n) begin
      thr_k      = tts_pkg::SUPPRESS_RST;
      min_log2_r = tts_pkg::MIN_LOG2_RST;
      max_dbl_r  = tts_pkg::MAX_DBL_RST;
      dbl_cnt    = 4'd0;
      elapsed    = '0;
      fire_at    = fire_from(span_of(4'd0), 16'd0);
      heard      = 8'd0;
      fired      = 1'b0;
      last_id    = 32'd0;
      next_seq   = 32'd1;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sent_id      = out_tdata;
        got.is_duplicate = out_tuser;
        if (sends_due.size() == 0) begin
          $error("unexpected send: sent_id %h is_duplicate %b", got.sent_id,
                 got.is_duplicate);
          err_count++;
        end else begin
          due = sends_due.pop_front();
          if (got.sent_id !== due.sent_id) begin
            $error("sent_id: expected %h, actual %h", due.sent_id, got.sent_id);
            err_count++;
          end
          if (got.is_duplicate !== due.is_duplicate) begin
            $error("is_duplicate: expected %b, actual %b", due.is_duplicate,
                   got.is_duplicate);
            err_count++;
          end
          results_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          tts_pkg::REG_SUPPRESS: thr_k      = cfg_data;
          tts_pkg::REG_MIN_LOG2: min_log2_r = cfg_data[4:0];
          tts_pkg::REG_MAX_DBL:  max_dbl_r  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it.action     = in_tuser;
        it.recv_id    = in_tdata[31:0];
        it.rand_value = in_tdata[47:32];
        it.dup_coin   = in_tdata[48];
        sends = timer_advance(it, due);
        case (pin_kind)
          CHK_SEND: sends_due.push_back(pin_want);
          CHK_NONE: ;
          default: begin
            if (sends) begin
              sends_due.push_back(due);
            end
          end
        endcase
        items_taken++;
      end
    end
  end

  // Ends the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("trickle_timer_suppression_test: done, errors");
        $finish;
      end
    end
  end

  // Result side: random back-pressure unless calm, plus one long hold when requested.
  initial begin : sink
    int k;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offers one item, with random idle cycles ahead of it unless calm.
  task automatic offer_item(input tts_pkg::tts_item_t it, input pin_t pk,
                            input send_t pv);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {7'd0, it.dup_coin, it.rand_value, it.recv_id};
    pin_kind  <= pk;
    pin_want  <= pv;
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every predicted send is out and the pipeline is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sends_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [7:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic act, input logic [31:0] id,
                                         input logic [15:0] rnd, input logic coin,
                                         input pin_t pk, input logic [31:0] wid,
                                         input logic wdup);
    plan_row_t r;
    r = '0;
    r.kind                = ROW_ITEM;
    r.item.action         = act;
    r.item.recv_id        = id;
    r.item.rand_value     = rnd;
    r.item.dup_coin       = coin;
    r.pin                 = pk;
    r.want.sent_id        = wid;
    r.want.is_duplicate   = wdup;
    return r;
  endfunction

  // Register settings for the random part; a negative threshold draws all at random.
  phase_t phase_plan [13] = '{
    '{1,   1,  3,  150, 20, 1'b0, 1'b1, 1'b0},
    '{2,   2,  5,  150, 15, 1'b0, 1'b0, 1'b0},
    '{255, 0,  0,  250, 5,  1'b0, 1'b0, 1'b1},
    '{1,   1,  11, 40,  0,  1'b0, 1'b0, 1'b0},
    '{255, 31, 11, 30,  0,  1'b0, 1'b0, 1'b0},
    '{255, 20, 11, 40,  30, 1'b0, 1'b0, 1'b0},
    '{3,   2,  0,  120, 20, 1'b0, 1'b0, 1'b0},
    '{255, 3,  2,  300, 0,  1'b1, 1'b0, 1'b0},
    '{-1,  0,  0,  120, 20, 1'b0, 1'b0, 1'b0},
    '{-1,  0,  0,  120, 20, 1'b0, 1'b0, 1'b0},
    '{-1,  0,  0,  120, 20, 1'b0, 1'b0, 1'b0},
    '{-1,  0,  0,  120, 20, 1'b0, 1'b0, 1'b0},
    '{-1,  0,  0,  120, 20, 1'b0, 1'b0, 1'b0}
  };

  initial begin : stimulus
    plan_row_t          directed_plan[$];
    plan_row_t          r;
    phase_t             ph;
    tts_pkg::tts_item_t it;
    logic [31:0]        prev_id;
    int                 i;
    int                 p;
    int                 pick;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= tts_pkg::ACT_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= tts_pkg::REG_SUPPRESS;
    cfg_data  <= '0;
    pin_kind  <= CHK_MODEL;
    pin_want  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: one-tick intervals first, so every tick reaches a fire point.
    directed_plan.push_back(cfg_row(tts_pkg::REG_MIN_LOG2, 8'd0));
    directed_plan.push_back(cfg_row(tts_pkg::REG_MAX_DBL, 8'd0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b0,
                                     CHK_MODEL, 32'd0, 1'b0));
    // First send is a new id even with the coin low.
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b0,
                                     CHK_SEND, 32'd1, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'hFFFF, 1'b0,
                                     CHK_SEND, 32'd1, 1'b1));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_SEND, 32'd2, 1'b0));
    // Two equal ids reach the threshold of one and suppress the next send.
    directed_plan.push_back(item_row(tts_pkg::ACT_MSG, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_MSG, 32'hFFFF_FFFF, 16'h0, 1'b0,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_SEND, 32'd3, 1'b0));
    // A threshold of zero never sends.
    directed_plan.push_back(cfg_row(tts_pkg::REG_SUPPRESS, 8'd0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(cfg_row(tts_pkg::REG_SUPPRESS, 8'd255));
    directed_plan.push_back(item_row(tts_pkg::ACT_MSG, 32'h0, 16'h0, 1'b0,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_MSG, 32'h0, 16'h0, 1'b0,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b0,
                                     CHK_SEND, 32'd3, 1'b1));
    // Growing intervals, then a new id that restarts the minimum interval.
    directed_plan.push_back(cfg_row(tts_pkg::REG_MIN_LOG2, 8'd1));
    directed_plan.push_back(cfg_row(tts_pkg::REG_MAX_DBL, 8'd11));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'hFFFF, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'hFFFF, 1'b0,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'hFFFF, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b0,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h5A5A, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_MSG, 32'h1234_5678, 16'hA5A5, 1'b1,
                                     CHK_NONE, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));
    directed_plan.push_back(item_row(tts_pkg::ACT_TICK, 32'h0, 16'h0, 1'b1,
                                     CHK_MODEL, 32'd0, 1'b0));

    foreach (directed_plan[i]) begin
      r = directed_plan[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.idx, r.val);
      end else begin
        offer_item(r.item, r.pin, r.want);
      end
    end

    // Random part: one register setting per phase, written while idle.
    prev_id = 32'h1234_5678;
    for (p = 0; p < $size(phase_plan); p++) begin
      ph = phase_plan[p];
      if (ph.thresh < 0) begin
        ph.thresh   = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 4);
        ph.min_log2 = $urandom_range(0, 3);
        ph.max_dbl  = $urandom_range(0, 5);
      end
      settle();
      write_reg(tts_pkg::REG_SUPPRESS, 8'(ph.thresh));
      write_reg(tts_pkg::REG_MIN_LOG2, 8'(ph.min_log2));
      write_reg(tts_pkg::REG_MAX_DBL, 8'(ph.max_dbl));
      calm = ph.calm;
      if (ph.squeeze) begin
        squeeze_req = 1'b1;
      end
      for (i = 0; i < ph.n_items; i++) begin
        it.rand_value = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          it.rand_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        it.dup_coin = 1'($urandom_range(0, 1));
        if (ph.burst) begin
          // A long run of one id drives the heard count into saturation.
          it.action  = (i < 271) ? tts_pkg::ACT_MSG : tts_pkg::ACT_TICK;
          it.recv_id = (i == 0) ? $urandom : prev_id;
        end else begin
          it.action = ($urandom_range(0, 99) < ph.msg_pct) ? tts_pkg::ACT_MSG :
                                                               tts_pkg::ACT_TICK;
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            it.recv_id = prev_id;
          end else if (pick == 6) begin
            it.recv_id = 32'h0;
          end else if (pick == 7) begin
            it.recv_id = 32'hFFFF_FFFF;
          end else begin
            it.recv_id = $urandom;
          end
        end
        if (it.action == tts_pkg::ACT_MSG) begin
          prev_id = it.recv_id;
        end
        offer_item(it, CHK_MODEL, '0);
      end
      calm = 1'b0;
    end

    settle();
    $display("%0d items taken, %0d sends checked, %0d register writes", items_taken,
             results_seen, reg_writes);
    $display("covered: suppression, duplicates, count and exponent saturation, long stall");
    if (err_count == 0) begin
      $display("trickle_timer_suppression_test: done, clean");
    end else begin
      $display("trickle_timer_suppression_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tts_pkg.sv
rtl/tts_core.sv
rtl/trickle_timer_suppression.sv
rtl/tts_checker.sv
test/trickle_timer_suppression_test.sv
